FILE: rtl/tfn_pkg.sv
// Package for the triangle face normal block: widths, word types and index codes.
// No dependencies; every rtl module refers to it by scoped names.
`default_nettype none
package tfn_pkg;
   localparam int IN_W        = 32;
   localparam int OUT_W       = 32;
   localparam int COORD_WIDTH = 32;
   localparam int EW          = COORD_WIDTH + 1;   // edge component
   localparam int PW          = 2 * EW;            // edge product
   localparam int CRW         = PW + 1;            // cross product component
   localparam int MW          = CRW;               // cross magnitude
   localparam int SQW         = 2 * MW;            // squared component
   localparam int SW          = SQW + 2;           // sum of three squares
   localparam int DIV_STEPS   = 63;                // quotient of c^2 * 2^62 / s
   localparam int DPW         = 64;                // quotient padded to even width
   localparam int RW          = DPW / 2;           // integer square root
   localparam int RRW         = RW + 3;            // root remainder
   localparam int CNTW        = $clog2(MW);
   localparam int Q_DEPTH     = 4;
   localparam int QAW         = $clog2(Q_DEPTH);
   localparam int QCW         = $clog2(Q_DEPTH + 1);
   localparam int COPIES      = 3;
   localparam int CPW         = 2;
   localparam logic [CPW-1:0] LAST_COPY = CPW'(COPIES - 1);

   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;

   typedef struct packed {
      logic [IN_W-1:0] v0x, v0y, v0z;
      logic [IN_W-1:0] v1x, v1y, v1z;
      logic [IN_W-1:0] v2x, v2y, v2z;
   } tri_type;

   typedef struct packed {
      logic signed [CRW-1:0] x, y, z;
   } cross_type;

   typedef struct packed {
      logic [OUT_W-1:0] x, y, z;
      logic             degen;
   } normal_type;
endpackage
`default_nettype wire

FILE: rtl/triangle_face_normal.sv
// Top level of the triangle face normal block: front end, queue, back end, output stage.
// Depends on tfn_pkg, tfn_front, tfn_queue, tfn_back and tfn_emit.
//
//  channel | handshake            | word
//  req     | req_valid/req_ready  | nine Q16.16 vertex coordinates
//  rsp     | rsp_valid/rsp_ready  | Q1.30 normal, degenerate, last (three per triangle)
//
// The front end takes a triangle every cycle, unless the queue is full and stalls it, into a
// three-stage cross product pipe and a four-entry queue. The back end works on one triangle at
// a time: serial squaring of each component, then per component 63 division and 32 root steps.
// Reset is synchronous and clears all handshake state. Either side may stall freely.
`default_nettype none
module triangle_face_normal (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  signed [31:0] req_v0_x,
   input  wire  signed [31:0] req_v0_y,
   input  wire  signed [31:0] req_v0_z,
   input  wire  signed [31:0] req_v1_x,
   input  wire  signed [31:0] req_v1_y,
   input  wire  signed [31:0] req_v1_z,
   input  wire  signed [31:0] req_v2_x,
   input  wire  signed [31:0] req_v2_y,
   input  wire  signed [31:0] req_v2_z,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic signed [31:0] rsp_normal_x,
   output logic signed [31:0] rsp_normal_y,
   output logic signed [31:0] rsp_normal_z,
   output logic        rsp_degenerate,
   output logic        rsp_last
);
   tfn_pkg::tri_type    tri_w;
   tfn_pkg::cross_type  f_cross, q_cross;
   tfn_pkg::normal_type b_nrm, e_nrm;
   logic f_valid, f_ready, q_valid, q_ready, b_valid, b_ready;

   assign tri_w = '{v0x: req_v0_x, v0y: req_v0_y, v0z: req_v0_z,
                    v1x: req_v1_x, v1y: req_v1_y, v1z: req_v1_z,
                    v2x: req_v2_x, v2y: req_v2_y, v2z: req_v2_z};

   tfn_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_tri(tri_w),
      .out_valid(f_valid), .out_ready(f_ready), .out_cross(f_cross)
   );

   tfn_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(f_valid), .push_ready(f_ready), .push_data(f_cross),
      .pop_valid(q_valid), .pop_ready(q_ready), .pop_data(q_cross)
   );

   tfn_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_cross(q_cross),
      .out_valid(b_valid), .out_ready(b_ready), .out_nrm(b_nrm)
   );

   tfn_emit u_emit (
      .clock(clock), .reset(reset),
      .in_valid(b_valid), .in_ready(b_ready), .in_nrm(b_nrm),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_nrm(e_nrm), .rsp_last(rsp_last)
   );

   assign rsp_normal_x   = signed'(e_nrm.x);
   assign rsp_normal_y   = signed'(e_nrm.y);
   assign rsp_normal_z   = signed'(e_nrm.z);
   assign rsp_degenerate = e_nrm.degen;
endmodule
`default_nettype wire

FILE: rtl/tfn_front.sv
// Front end: accepts triangle words, forms edges, products and the cross product.
// Three-stage pipeline, stalls as one when the queue is full. Uses tfn_pkg.
`default_nettype none
module tfn_front (
   input  wire              clock,
   input  wire              reset,
   input  wire              in_valid,
   output logic             in_ready,
   input  tfn_pkg::tri_type in_tri,
   output logic             out_valid,
   input  wire              out_ready,
   output tfn_pkg::cross_type out_cross
);
   function automatic logic signed [tfn_pkg::EW-1:0] sext(input logic [tfn_pkg::IN_W-1:0] r);
      sext = signed'({{(tfn_pkg::EW - tfn_pkg::COORD_WIDTH){r[tfn_pkg::COORD_WIDTH-1]}},
                      r[tfn_pkg::COORD_WIDTH-1:0]});
   endfunction

   logic v1_ff, v2_ff, v3_ff;
   logic signed [tfn_pkg::EW-1:0] a_ff [3];
   logic signed [tfn_pkg::EW-1:0] b_ff [3];
   logic signed [tfn_pkg::PW-1:0] p_ff [3];
   logic signed [tfn_pkg::PW-1:0] q_ff [3];
   tfn_pkg::cross_type c_ff;
   logic en;

   assign en        = !v3_ff || out_ready;
   assign in_ready  = en;
   assign out_valid = v3_ff;
   assign out_cross = c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // e1 = v2 - v1, e2 = v0 - v1
         a_ff[0] <= sext(in_tri.v2x) - sext(in_tri.v1x);
         a_ff[1] <= sext(in_tri.v2y) - sext(in_tri.v1y);
         a_ff[2] <= sext(in_tri.v2z) - sext(in_tri.v1z);
         b_ff[0] <= sext(in_tri.v0x) - sext(in_tri.v1x);
         b_ff[1] <= sext(in_tri.v0y) - sext(in_tri.v1y);
         b_ff[2] <= sext(in_tri.v0z) - sext(in_tri.v1z);
         p_ff[0] <= tfn_pkg::PW'(a_ff[1]) * tfn_pkg::PW'(b_ff[2]);
         q_ff[0] <= tfn_pkg::PW'(a_ff[2]) * tfn_pkg::PW'(b_ff[1]);
         p_ff[1] <= tfn_pkg::PW'(a_ff[2]) * tfn_pkg::PW'(b_ff[0]);
         q_ff[1] <= tfn_pkg::PW'(a_ff[0]) * tfn_pkg::PW'(b_ff[2]);
         p_ff[2] <= tfn_pkg::PW'(a_ff[0]) * tfn_pkg::PW'(b_ff[1]);
         q_ff[2] <= tfn_pkg::PW'(a_ff[1]) * tfn_pkg::PW'(b_ff[0]);
         c_ff.x  <= tfn_pkg::CRW'(p_ff[0]) - tfn_pkg::CRW'(q_ff[0]);
         c_ff.y  <= tfn_pkg::CRW'(p_ff[1]) - tfn_pkg::CRW'(q_ff[1]);
         c_ff.z  <= tfn_pkg::CRW'(p_ff[2]) - tfn_pkg::CRW'(q_ff[2]);
      end
   end
endmodule
`default_nettype wire

FILE: rtl/tfn_queue.sv
// Short queue of cross product words between front and back end.
// Register array with a count. Uses tfn_pkg.
`default_nettype none
module tfn_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push_valid,
   output logic               push_ready,
   input  tfn_pkg::cross_type push_data,
   output logic               pop_valid,
   input  wire                pop_ready,
   output tfn_pkg::cross_type pop_data
);
   tfn_pkg::cross_type mem_ff [tfn_pkg::Q_DEPTH];
   logic [tfn_pkg::QAW-1:0] wr_ff, rd_ff;
   logic [tfn_pkg::QCW-1:0] cnt_ff;
   logic push, pop;

   assign push_ready = cnt_ff != tfn_pkg::QCW'(tfn_pkg::Q_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end
endmodule
`default_nettype wire

FILE: rtl/tfn_back.sv
// Back end: serial squares, restoring division c^2*2^62/s and integer square root
// per component, then rounding and sign. One triangle at a time. Uses tfn_pkg.
`default_nettype none
module tfn_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  tfn_pkg::cross_type  in_cross,
   output logic                out_valid,
   input  wire                 out_ready,
   output tfn_pkg::normal_type out_nrm
);
   typedef enum logic [2:0] {ST_IDLE, ST_SQR, ST_DIV, ST_SQRT, ST_DONE} state_type;

   function automatic logic signed [tfn_pkg::CRW-1:0] sel_c(input tfn_pkg::cross_type c,
                                                           input logic [1:0] k);
      unique case (k)
         tfn_pkg::COMP_X: sel_c = c.x;
         tfn_pkg::COMP_Y: sel_c = c.y;
         default:         sel_c = c.z;
      endcase
   endfunction

   function automatic logic [tfn_pkg::MW-1:0] mag_of(input logic signed [tfn_pkg::CRW-1:0] v);
      logic signed [tfn_pkg::CRW-1:0] nv;
      nv = -v;
      mag_of = v[tfn_pkg::CRW-1] ? tfn_pkg::MW'(nv) : tfn_pkg::MW'(v);
   endfunction

   state_type state_ff;
   tfn_pkg::cross_type c_ff;
   logic [1:0] comp_ff;
   logic [tfn_pkg::CNTW-1:0] cnt_ff;
   logic [tfn_pkg::MW-1:0]  mag_ff, msh_ff;
   logic [tfn_pkg::SQW-1:0] acc_ff;
   logic [tfn_pkg::SQW-1:0] sq_ff [3];
   logic [tfn_pkg::SW-1:0]  s_ff;
   logic [tfn_pkg::SW:0]    rem_ff;
   logic [tfn_pkg::DPW-1:0] dq_ff;
   logic [tfn_pkg::RW-1:0]  root_ff;
   logic [tfn_pkg::RRW-1:0] srem_ff;
   logic                    neg_ff [3];
   logic [tfn_pkg::OUT_W-1:0] nrm_ff [3];
   logic                    degen_ff;

   logic [tfn_pkg::SQW-1:0] acc_in;
   logic [tfn_pkg::SW-1:0]  s_in;
   logic [tfn_pkg::SW:0]    t_div, rem_in;
   logic                    ge_div;
   logic [tfn_pkg::RRW-1:0] t_sq, trial, srem_in;
   logic                    ge_sq;
   logic [tfn_pkg::RW-1:0]  root_in;
   logic [tfn_pkg::RW:0]    rnd;
   logic [tfn_pkg::OUT_W-1:0] qmag, nval;
   logic [1:0]              comp_nx;
   logic signed [tfn_pkg::CRW-1:0] c_nx;

   assign in_ready  = state_ff == ST_IDLE;
   assign out_valid = state_ff == ST_DONE;
   assign out_nrm   = '{x: nrm_ff[0], y: nrm_ff[1], z: nrm_ff[2], degen: degen_ff};

   always_comb begin
      comp_nx = comp_ff + 2'd1;
      c_nx    = sel_c(c_ff, comp_nx);
      acc_in  = {acc_ff[tfn_pkg::SQW-2:0], 1'b0}
              + (msh_ff[tfn_pkg::MW-1] ? tfn_pkg::SQW'(mag_ff) : '0);
      s_in    = s_ff + tfn_pkg::SW'(acc_in);
      // first division step tests c^2 >= s without a shift
      t_div   = (cnt_ff == '0) ? rem_ff : {rem_ff[tfn_pkg::SW-1:0], 1'b0};
      ge_div  = t_div >= {1'b0, s_ff};
      rem_in  = ge_div ? t_div - {1'b0, s_ff} : t_div;
      t_sq    = {srem_ff[tfn_pkg::RRW-3:0], dq_ff[tfn_pkg::DPW-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      ge_sq   = t_sq >= trial;
      srem_in = ge_sq ? t_sq - trial : t_sq;
      root_in = {root_ff[tfn_pkg::RW-2:0], ge_sq};
      // the root plus one, halved, gives the magnitude rounded to nearest
      rnd     = {1'b0, root_in} + 1'b1;
      qmag    = rnd[tfn_pkg::RW:1];
      nval    = neg_ff[comp_ff] ? -qmag : qmag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (in_valid) begin
                  c_ff      <= in_cross;
                  comp_ff   <= tfn_pkg::COMP_X;
                  cnt_ff    <= '0;
                  mag_ff    <= mag_of(in_cross.x);
                  msh_ff    <= mag_of(in_cross.x);
                  neg_ff[0] <= in_cross.x[tfn_pkg::CRW-1];
                  acc_ff    <= '0;
                  s_ff      <= '0;
                  state_ff  <= ST_SQR;
               end
            end
            ST_SQR: begin
               if (cnt_ff == tfn_pkg::CNTW'(tfn_pkg::MW - 1)) begin
                  sq_ff[comp_ff] <= acc_in;
                  s_ff   <= s_in;
                  cnt_ff <= '0;
                  acc_ff <= '0;
                  if (comp_ff == tfn_pkg::COMP_Z) begin
                     degen_ff <= s_in == '0;
                     comp_ff  <= tfn_pkg::COMP_X;
                     rem_ff   <= {1'b0, 2'b00, sq_ff[tfn_pkg::COMP_X]};
                     dq_ff    <= '0;
                     if (s_in == '0) begin
                        nrm_ff[0] <= '0;
                        nrm_ff[1] <= '0;
                        nrm_ff[2] <= '0;
                        state_ff  <= ST_DONE;
                     end else begin
                        state_ff  <= ST_DIV;
                     end
                  end else begin
                     comp_ff         <= comp_nx;
                     mag_ff          <= mag_of(c_nx);
                     msh_ff          <= mag_of(c_nx);
                     neg_ff[comp_nx] <= c_nx[tfn_pkg::CRW-1];
                  end
               end else begin
                  acc_ff <= acc_in;
                  msh_ff <= {msh_ff[tfn_pkg::MW-2:0], 1'b0};
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_DIV: begin
               rem_ff <= rem_in;
               dq_ff  <= {dq_ff[tfn_pkg::DPW-2:0], ge_div};
               if (cnt_ff == tfn_pkg::CNTW'(tfn_pkg::DIV_STEPS - 1)) begin
                  cnt_ff   <= '0;
                  root_ff  <= '0;
                  srem_ff  <= '0;
                  state_ff <= ST_SQRT;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_SQRT: begin
               srem_ff <= srem_in;
               root_ff <= root_in;
               if (cnt_ff == tfn_pkg::CNTW'(tfn_pkg::RW - 1)) begin
                  nrm_ff[comp_ff] <= nval;
                  cnt_ff <= '0;
                  if (comp_ff == tfn_pkg::COMP_Z) begin
                     state_ff <= ST_DONE;
                  end else begin
                     comp_ff  <= comp_nx;
                     rem_ff   <= {1'b0, 2'b00, sq_ff[comp_nx]};
                     dq_ff    <= '0;
                     state_ff <= ST_DIV;
                  end
               end else begin
                  dq_ff  <= {dq_ff[tfn_pkg::DPW-3:0], 2'b00};
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_DONE: begin
               if (out_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: rtl/tfn_emit.sv
// Output stage: holds one normal and sends it as three result words, last on the third.
// Takes the next normal as the third copy leaves. Uses tfn_pkg.
`default_nettype none
module tfn_emit (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  tfn_pkg::normal_type in_nrm,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output tfn_pkg::normal_type rsp_nrm,
   output logic                rsp_last
);
   logic busy_ff;
   logic [tfn_pkg::CPW-1:0] cnt_ff;
   tfn_pkg::normal_type hold_ff;
   logic fin;

   assign rsp_valid = busy_ff;
   assign rsp_nrm   = hold_ff;
   assign rsp_last  = cnt_ff == tfn_pkg::LAST_COPY;
   assign fin       = busy_ff && rsp_ready && rsp_last;
   assign in_ready  = !busy_ff || fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (in_valid && in_ready) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (fin) begin
         busy_ff <= 1'b0;
      end else if (busy_ff && rsp_ready) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) hold_ff <= in_nrm;
   end
endmodule
`default_nettype wire
